// ===== hdl/rdiv_pkg.sv =====
package rdiv_pkg;

    // Field widths of one input beat and one result beat.
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 8;
    localparam int COUNT_W    = 3;
    localparam int QUOTIENT_W = 32;
    localparam int REM_W      = 8;

    // Microprogram counter width.
    localparam int PC_W = 3;

    // Datapath operations selected by a control word.
    typedef logic [1:0] t_dp_op;
    localparam t_dp_op OP_NOP    = 2'd0;
    localparam t_dp_op OP_STEP   = 2'd1;
    localparam t_dp_op OP_POST_Q = 2'd2;
    localparam t_dp_op OP_POST_Z = 2'd3;

    // Jump conditions tested by the sequencer.
    typedef logic [1:0] t_cond;
    localparam t_cond COND_BEAT        = 2'd0;
    localparam t_cond COND_DIV_ZERO    = 2'd1;
    localparam t_cond COND_MORE_BITS   = 2'd2;
    localparam t_cond COND_OUT_BLOCKED = 2'd3;

    // Control that the sequencer hands to the datapath.
    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_ctrl;

    // Status that the datapath returns for the jump conditions.
    typedef struct packed {
        logic beat;
        logic div_zero;
        logic more_bits;
        logic out_blocked;
    } t_dp_status;

endpackage

// ===== hdl/rdiv_if.sv =====
// Input channel: one division request per beat.
interface rdiv_in_if;
    logic                             valid;
    logic                             ready;
    logic [rdiv_pkg::DIVIDEND_W-1:0]  dividend;
    logic [rdiv_pkg::DIVISOR_W-1:0]   divisor_byte;
    logic [rdiv_pkg::COUNT_W-1:0]     byte_count;

    modport source (output valid, output dividend, output divisor_byte,
                    output byte_count, input ready);
    modport sink   (input valid, input dividend, input divisor_byte,
                    input byte_count, output ready);
endinterface

// Output channel: one result per beat.
interface rdiv_out_if;
    logic                             valid;
    logic                             ready;
    logic [rdiv_pkg::QUOTIENT_W-1:0]  quotient;
    logic [rdiv_pkg::REM_W-1:0]       remainder_byte;
    logic                             divide_by_zero;

    modport source (output valid, output quotient, output remainder_byte,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder_byte,
                    input divide_by_zero, output ready);
endinterface

// ===== hdl/rdiv_sequencer.sv =====
module rdiv_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdiv_pkg::t_dp_status i_status,
    output rdiv_pkg::t_dp_ctrl   o_ctrl
);
    import rdiv_pkg::*;

    // Microprogram addresses.
    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
    localparam logic [PC_W-1:0] PC_STEP   = 3'd2;
    localparam logic [PC_W-1:0] PC_POST_Q = 3'd3;
    localparam logic [PC_W-1:0] PC_POST_Z = 3'd4;

    // One control word: datapath control, a condition and two successors.
    typedef struct packed {
        t_dp_ctrl        dp;
        t_cond           cond;
        logic [PC_W-1:0] next_true;
        logic [PC_W-1:0] next_false;
    } t_ucode_word;

    // The microprogram. Unused addresses fall back to the wait step.
    function automatic t_ucode_word ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode_word w;
        unique case (pc)
            PC_WAIT:   w = '{dp: '{in_ready: 1'b1, op: OP_NOP},
                             cond: COND_BEAT, next_true: PC_CHECK,
                             next_false: PC_WAIT};
            PC_CHECK:  w = '{dp: '{in_ready: 1'b0, op: OP_NOP},
                             cond: COND_DIV_ZERO, next_true: PC_POST_Z,
                             next_false: PC_STEP};
            PC_STEP:   w = '{dp: '{in_ready: 1'b0, op: OP_STEP},
                             cond: COND_MORE_BITS, next_true: PC_STEP,
                             next_false: PC_POST_Q};
            PC_POST_Q: w = '{dp: '{in_ready: 1'b0, op: OP_POST_Q},
                             cond: COND_OUT_BLOCKED, next_true: PC_POST_Q,
                             next_false: PC_WAIT};
            PC_POST_Z: w = '{dp: '{in_ready: 1'b0, op: OP_POST_Z},
                             cond: COND_OUT_BLOCKED, next_true: PC_POST_Z,
                             next_false: PC_WAIT};
            default:   w = '{dp: '{in_ready: 1'b0, op: OP_NOP},
                             cond: COND_BEAT, next_true: PC_WAIT,
                             next_false: PC_WAIT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ucode_word     w_word;
    logic            w_cond;

    assign w_word = ucode_rom(r_pc);
    assign o_ctrl = w_word.dp;

    // Select the tested condition.
    always_comb begin
        unique case (w_word.cond)
            COND_BEAT:        w_cond = i_status.beat;
            COND_DIV_ZERO:    w_cond = i_status.div_zero;
            COND_MORE_BITS:   w_cond = i_status.more_bits;
            COND_OUT_BLOCKED: w_cond = i_status.out_blocked;
            default:          w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_word.next_true : w_word.next_false;
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/rdiv_datapath.sv =====
module rdiv_datapath #(
    parameter int DIVIDEND_BYTES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rdiv_pkg::t_dp_ctrl   i_ctrl,
    output rdiv_pkg::t_dp_status o_status,
    rdiv_in_if.sink              i_in,
    rdiv_out_if.source           o_out
);
    import rdiv_pkg::*;

    // Width of the clamped byte count and of the bit counter.
    localparam int CNT_W  = $clog2(DIVIDEND_BYTES + 1);
    localparam int BITS_W = CNT_W + 3;

    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_div;
    logic [REM_W-1:0]      r_rem;
    logic [QUOTIENT_W-1:0] r_q;
    logic [BITS_W-1:0]     r_bits;
    logic                  r_single;
    logic [REM_W-1:0]      r_b1;

    logic                  r_out_valid;
    logic [QUOTIENT_W-1:0] r_out_q;
    logic [REM_W-1:0]      r_out_rem;
    logic                  r_out_dz;

    logic                  w_beat;
    logic                  w_out_blocked;
    logic                  w_post;
    logic [CNT_W-1:0]      w_count;
    logic [REM_W:0]        w_trial;
    logic [REM_W:0]        w_diff;
    logic                  w_fits;

    assign i_in.ready    = i_ctrl.in_ready;
    assign w_beat        = i_in.valid & i_ctrl.in_ready;
    assign w_out_blocked = r_out_valid & ~o_out.ready;
    assign w_post        = ~w_out_blocked &
                           ((i_ctrl.op == OP_POST_Q) | (i_ctrl.op == OP_POST_Z));

    assign o_status.beat        = w_beat;
    assign o_status.div_zero    = (r_div == '0);
    assign o_status.more_bits   = (r_bits != BITS_W'(1));
    assign o_status.out_blocked = w_out_blocked;

    // Clamp the byte count to the range one to DIVIDEND_BYTES.
    always_comb begin
        priority if (i_in.byte_count == '0) begin
            w_count = CNT_W'(1);
        end else if (int'(i_in.byte_count) > DIVIDEND_BYTES) begin
            w_count = CNT_W'(DIVIDEND_BYTES);
        end else begin
            w_count = CNT_W'(i_in.byte_count);
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_num[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (w_beat) begin
            r_num    <= i_in.dividend;
            r_div    <= i_in.divisor_byte;
            r_rem    <= '0;
            r_q      <= '0;
            r_bits   <= {w_count, 3'b000};
            r_single <= (w_count == CNT_W'(1));
            r_b1     <= i_in.dividend[DIVIDEND_W-9 -: REM_W];
        end else if (i_ctrl.op == OP_STEP) begin
            r_num  <= {r_num[DIVIDEND_W-2:0], 1'b0};
            r_rem  <= w_fits ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_q    <= {r_q[QUOTIENT_W-2:0], w_fits};
            r_bits <= r_bits - BITS_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_post) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload. A single-byte count returns the second dividend byte.
    always_ff @(posedge i_clk) begin
        if (w_post) begin
            if (i_ctrl.op == OP_POST_Z) begin
                r_out_q   <= '0;
                r_out_rem <= '0;
                r_out_dz  <= 1'b1;
            end else begin
                r_out_q   <= r_q;
                r_out_rem <= r_single ? r_b1 : r_rem;
                r_out_dz  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.quotient       = r_out_q;
    assign o_out.remainder_byte = r_out_rem;
    assign o_out.divide_by_zero = r_out_dz;

endmodule

// ===== hdl/restoring_divide_32_by_8.sv =====
// Divides the number formed by the leading 1 to DIVIDEND_BYTES bytes of a
// big-endian 32-bit dividend by an unsigned 8-bit divisor and returns a 32-bit
// quotient and a remainder byte; for a count of one the remainder byte is the
// second dividend byte unchanged, and a zero divisor returns zeros with the
// divide_by_zero flag set. A count of zero acts as one and a count above
// DIVIDEND_BYTES acts as DIVIDEND_BYTES. A small microprogram drives a
// bit-serial restoring divider that produces one quotient bit per cycle. After
// the input beat the microprogram checks the divisor, steps once per quotient
// bit and then posts the result, or posts zeros at once for a zero divisor.
// One item is worked at a time, and the next input beat is taken as soon as
// the result sits in the output register, even while it waits to be taken.
module restoring_divide_32_by_8 #(
    parameter int DIVIDEND_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdiv_in_if.sink     i_in,
    rdiv_out_if.source  o_out
);
    import rdiv_pkg::*;

    t_dp_ctrl   w_ctrl;
    t_dp_status w_status;

    rdiv_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    rdiv_datapath #(
        .DIVIDEND_BYTES (DIVIDEND_BYTES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule
